// File: rtl/nmpn_pkg.sv
// shared types, constants and helpers for the nm pdu partial network filter
package nmpn_pkg;

    // longest pdu that can ever match the configured length
    localparam int MAX_PDU_BYTES = 64;

    // byte counter saturation value
    localparam logic [6:0] CNT_MAX = 7'd127;

    // control bit vector bits
    localparam int RMR_BIT_POS = 0;
    localparam int PNI_BIT_POS = 6;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PDU_LENGTH      = 3'd0,
        REG_CBV_POSITION    = 3'd1,
        REG_NID_POSITION    = 3'd2,
        REG_MODE_FLAGS      = 3'd3,
        REG_DETECT_NODE     = 3'd4,
        REG_PN_CONFIG_MASK  = 3'd5,
        REG_PN_FILTER_MASK  = 3'd6,
        REG_PN_FILTER_BYTES = 3'd7
    } reg_idx_t;

    // mode flag bits
    localparam int MODE_PN_PART   = 0;
    localparam int MODE_ALL_AWAKE = 1;
    localparam int MODE_RR_CHECK  = 2;

    typedef struct packed {
        logic [6:0]  pdu_length;
        logic [6:0]  cbv_position;
        logic [6:0]  nid_position;
        logic [2:0]  mode_flags;
        logic        detect_node;
        logic [63:0] pn_config_mask;
        logic [63:0] pn_filter_mask;
        logic [3:0]  pn_filter_bytes;
    } cfg_t;

    // finished frame handed from the accumulator to the evaluation stage
    typedef struct packed {
        logic       length_ok;
        logic [7:0] node_byte;
        logic [7:0] control_byte;
    } frame_t;

    // evaluated result
    typedef struct packed {
        logic [63:0] valid_pn_mask;
        logic        repeat_request;
        logic [7:0]  node_id;
        logic        indication;
        logic        length_ok;
    } result_t;

    // byte k of the mask is set when k < n, all bytes from eight upwards
    function automatic logic [63:0] bytes_mask(input logic [6:0] n);
        logic [63:0] m;
        for (int k = 0; k < 8; k++) begin
            m[k*8 +: 8] = (n > 7'(k)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: rtl/nmpn_cfg.sv
// configuration register file of the nm pdu filter
module nmpn_cfg
    import nmpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PDU_LENGTH:      cfg_next.pdu_length      = cfg_data[6:0];
                REG_CBV_POSITION:    cfg_next.cbv_position    = cfg_data[6:0];
                REG_NID_POSITION:    cfg_next.nid_position    = cfg_data[6:0];
                REG_MODE_FLAGS:      cfg_next.mode_flags      = cfg_data[2:0];
                REG_DETECT_NODE:     cfg_next.detect_node     = cfg_data[0];
                REG_PN_CONFIG_MASK:  cfg_next.pn_config_mask  = cfg_data;
                REG_PN_FILTER_MASK:  cfg_next.pn_filter_mask  = cfg_data;
                REG_PN_FILTER_BYTES: cfg_next.pn_filter_bytes = cfg_data[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pdu_length      <= 7'd8;
            cfg_reg.cbv_position    <= 7'd0;
            cfg_reg.nid_position    <= 7'd1;
            cfg_reg.mode_flags      <= 3'd0;
            cfg_reg.detect_node     <= 1'b0;
            cfg_reg.pn_config_mask  <= 64'd0;
            cfg_reg.pn_filter_mask  <= 64'd0;
            cfg_reg.pn_filter_bytes <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/nmpn_acc.sv
// per-byte frame accumulator: count, field capture and pn bit collection
module nmpn_acc
    import nmpn_pkg::*;
#(
    parameter int PN_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output logic               rec_valid,
    input  logic               rec_ready,
    output frame_t             rec,
    output logic [PN_BITS-1:0] rec_pn
);

    logic [6:0]         cnt_reg;
    logic [6:0]         cnt_next;
    logic [7:0]         node_reg;
    logic [7:0]         node_next;
    logic [7:0]         ctrl_reg;
    logic [7:0]         ctrl_next;
    logic [PN_BITS-1:0] pn_reg;
    logic [PN_BITS-1:0] pn_next;
    logic               rec_valid_reg;
    logic               rec_valid_next;
    frame_t             rec_reg;
    logic [PN_BITS-1:0] rec_pn_reg;

    logic               fire;
    logic               cbv_on;
    logic               nid_on;
    logic [6:0]         cnt_inc;
    logic [7:0]         node_cur;
    logic [7:0]         ctrl_cur;
    logic [PN_BITS-1:0] pn_cur;
    logic               len_ok;

    assign in_ready = !rec_valid_reg || rec_ready;
    assign fire     = in_valid && in_ready;

    assign cbv_on = !cfg.cbv_position[6];
    assign nid_on = !cfg.nid_position[6];

    always_comb
    begin
        cnt_inc  = (cnt_reg != CNT_MAX) ? cnt_reg + 7'd1 : cnt_reg;
        ctrl_cur = (cbv_on && cnt_reg == {1'b0, cfg.cbv_position[5:0]}) ? in_byte : ctrl_reg;
        node_cur = (nid_on && cnt_reg == {1'b0, cfg.nid_position[5:0]}) ? in_byte : node_reg;
        for (int i = 0; i < PN_BITS; i++)
        begin
            pn_cur[i] = pn_reg[i] || (cnt_reg == 7'(i / 8) && in_byte[i % 8]);
        end
        len_ok = ({2'b00, cfg.pdu_length} <= 9'(MAX_PDU_BYTES)) &&
                 (cnt_inc == cfg.pdu_length);
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        node_next      = node_reg;
        ctrl_next      = ctrl_reg;
        pn_next        = pn_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;
        if (fire)
        begin
            if (in_last)
            begin
                cnt_next       = '0;
                node_next      = '0;
                ctrl_next      = '0;
                pn_next        = '0;
                rec_valid_next = 1'b1;
            end
            else
            begin
                cnt_next  = cnt_inc;
                node_next = node_cur;
                ctrl_next = ctrl_cur;
                pn_next   = pn_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            node_reg      <= '0;
            ctrl_reg      <= '0;
            pn_reg        <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            node_reg      <= node_next;
            ctrl_reg      <= ctrl_next;
            pn_reg        <= pn_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last)
        begin
            rec_reg.length_ok    <= len_ok;
            rec_reg.node_byte    <= node_cur;
            rec_reg.control_byte <= ctrl_cur;
            rec_pn_reg           <= pn_cur;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;
    assign rec_pn    = rec_pn_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last |=> cnt_reg == 7'd0 && pn_reg == '0)
        else $error("frame state not cleared after last byte");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !in_last && cnt_reg != CNT_MAX |=> cnt_reg == $past(cnt_reg) + 7'd1)
        else $error("byte counter did not advance");

    a_rec_source: assert property (@(posedge clk) disable iff (!rst_n)
        !rec_valid_reg ##1 rec_valid_reg |-> $past(fire && in_last))
        else $error("frame record appeared without a last byte");

endmodule

// File: rtl/nmpn_eval.sv
// end-of-frame evaluation and result register
module nmpn_eval
    import nmpn_pkg::*;
#(
    parameter int PN_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               rec_valid,
    output logic               rec_ready,
    input  frame_t             rec,
    input  logic [PN_BITS-1:0] rec_pn,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            res
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_next;

    logic        cbv_on;
    logic        nid_on;
    logic        pn_part;
    logic [63:0] cand;
    logic [63:0] valid;
    logic        rr;
    logic        ind;

    assign rec_ready = !out_valid_reg || out_ready;

    assign cbv_on  = !cfg.cbv_position[6];
    assign nid_on  = !cfg.nid_position[6];
    assign pn_part = cfg.mode_flags[MODE_PN_PART];

    always_comb
    begin
        cand  = cfg.pn_config_mask & 64'(rec_pn) & bytes_mask(cfg.pdu_length);
        valid = '0;
        if (cbv_on && rec.control_byte[PNI_BIT_POS] && pn_part)
        begin
            if (cfg.pn_filter_bytes == 4'd0)
                valid = cand;
            else
                valid = cand & cfg.pn_filter_mask & bytes_mask({3'b000, cfg.pn_filter_bytes});
        end
        rr = cbv_on && rec.control_byte[RMR_BIT_POS] &&
             !(cfg.mode_flags[MODE_RR_CHECK] && valid == '0 && pn_part);
        ind = (valid != '0) || cfg.mode_flags[MODE_ALL_AWAKE] ||
              (cfg.detect_node && nid_on) || rr;

        res_next.length_ok      = rec.length_ok;
        res_next.indication     = rec.length_ok && ind;
        res_next.node_id        = (rec.length_ok && nid_on) ? rec.node_byte : 8'h00;
        res_next.repeat_request = rec.length_ok && rr;
        res_next.valid_pn_mask  = rec.length_ok ? valid : 64'd0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (rec_valid && rec_ready)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_mismatch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.length_ok |-> !res_reg.indication &&
        !res_reg.repeat_request && res_reg.node_id == 8'h00 && res_reg.valid_pn_mask == 64'd0)
        else $error("length mismatch result carries data");

    a_rr_indicates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.repeat_request |-> res_reg.indication)
        else $error("repeat request without indication");

endmodule

// File: rtl/nm_pdu_partial_network_filter.sv
// top level of the nm pdu partial network receive filter
//
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata[7:0] rx_byte, s_tlast last_byte
// m_axis    out  m_tvalid/m_tready  m_tdata: length_ok, indication, node_id,
//                                   repeat_request, valid_pn_mask
// cfg       in   cfg_we             cfg_index register, cfg_data value
//
// one byte request is taken every cycle while s_tready is high; bytes that are not last give no result
// a frame's result is held first in the frame record register, then in the
// result register
// the result register and the frame record decouple the sides, so bytes keep
// flowing while one result waits; s_tready drops only when both are full
// reset clears the frame counter, captured bytes and both valid flags, and
// loads the register defaults; no clearing pass is needed
module nm_pdu_partial_network_filter
    import nmpn_pkg::*;
#(
    parameter int PN_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // last_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [0] length_ok, [1] indication, [9:2] node_id,
                                   // [10] repeat_request, [74:11] valid_pn_mask,
                                   // [79:75] zero
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t               cfg;
    logic               rec_valid;
    logic               rec_ready;
    frame_t             rec;
    logic [PN_BITS-1:0] rec_pn;
    result_t            res;

    // register file
    nmpn_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // byte counting and capture, frame record on the last byte
    nmpn_acc #(
        .PN_BITS (PN_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .rec_pn    (rec_pn)
    );

    // pn filtering, indication decision, result register
    nmpn_eval #(
        .PN_BITS (PN_BITS)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .rec_pn    (rec_pn),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    // pad the packed result up to whole bytes
    assign m_tdata = {5'b00000, res};

endmodule

// File: verif/nm_pdu_partial_network_filter_test.sv
// self-checking testbench for the nm pdu partial network receive filter
module nm_pdu_partial_network_filter_test
    import nmpn_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 5;
    localparam int RUN_LIMIT   = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_BYTES = 90;
    localparam int SETTLE      = 4;

    // every partial network index exists at the default width of 64
    localparam logic [63:0] PN_KEEP = '1;

    // one byte request on the receive side
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } rx_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] rx_byte
    logic        s_tlast = 1'b0;  // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // [0] length_ok, [1] indication, [9:2] node_id,
                                  // [10] repeat_request, [74:11] valid_pn_mask, [79:75] zero
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_PDU_LENGTH;
    logic [63:0] cfg_data = '0;

    // settings as the block should hold them, loaded with the reset defaults
    logic [6:0]  cur_pdu_len   = 7'd8;
    logic [6:0]  cur_cbv_pos   = 7'd0;
    logic [6:0]  cur_nid_pos   = 7'd1;
    logic [2:0]  cur_mode      = 3'd0;
    logic        cur_detect    = 1'b0;
    logic [63:0] cur_pn_mask   = '0;
    logic [63:0] cur_flt_mask  = '0;
    logic [3:0]  cur_flt_bytes = 4'd0;

    // frame being collected
    logic [6:0]  fr_count = '0;
    logic [7:0]  fr_nid   = '0;
    logic [7:0]  fr_cbv   = '0;
    logic [63:0] fr_bits  = '0;

    rx_req_t rx_bytes[$];   // byte requests still to be sent
    result_t verdicts[$];   // frame verdicts the block still owes

    bit byte_taken = 1'b0;  // a byte request completed at the last rising edge
    int idle_odds  = 0;     // percent chance that either side starts an idle burst
    int send_gap   = 0;
    int recv_gap   = 0;
    int mismatches = 0;
    int cycles     = 0;

    nm_pdu_partial_network_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // low n bytes set, the whole word from eight bytes upwards
    function automatic logic [63:0] span_mask(input int nbytes);
        if (nbytes >= 8)
            return '1;
        return (64'd1 << (8 * nbytes)) - 64'd1;
    endfunction

    // absorb one received byte; on the final byte work out the frame verdict
    // and start a fresh frame
    function automatic bit filter_byte(input logic [7:0] b, input logic fin,
                                       output result_t r);
        logic        cbv_on;
        logic        nid_on;
        logic        pn_part;
        logic [63:0] cand;
        r       = '0;
        cbv_on  = !cur_cbv_pos[6];
        nid_on  = !cur_nid_pos[6];
        pn_part = cur_mode[MODE_PN_PART];
        if (cbv_on && fr_count == cur_cbv_pos)
            fr_cbv = b;
        if (nid_on && fr_count == cur_nid_pos)
            fr_nid = b;
        // first eight bytes carry the partial network request bits
        if (fr_count < 7'd8)
            fr_bits = fr_bits | (64'(b) << (8 * fr_count));
        // counter holds at its top value on long frames
        if (fr_count != CNT_MAX)
            fr_count = fr_count + 7'd1;
        if (!fin)
            return 1'b0;

        // lengths beyond the longest pdu never match
        r.length_ok = (cur_pdu_len <= 7'(MAX_PDU_BYTES)) && (fr_count == cur_pdu_len);
        if (r.length_ok)
        begin
            if (nid_on)
                r.node_id = fr_nid;
            if (cbv_on)
            begin
                r.repeat_request = fr_cbv[RMR_BIT_POS];
                if (fr_cbv[PNI_BIT_POS] && pn_part)
                begin
                    // only networks whose byte lies inside the pdu can count
                    cand = cur_pn_mask & fr_bits & PN_KEEP & span_mask(cur_pdu_len);
                    if (cur_flt_bytes == 4'd0)
                        r.valid_pn_mask = cand;
                    else
                        r.valid_pn_mask = cand & cur_flt_mask & span_mask(cur_flt_bytes);
                    if (r.valid_pn_mask != '0)
                        r.indication = 1'b1;
                end
            end
            if (cur_mode[MODE_ALL_AWAKE])
                r.indication = 1'b1;
            if (cur_detect && nid_on)
                r.indication = 1'b1;
            // repeat request only survives the pn check with a relevant network
            if (cur_mode[MODE_RR_CHECK] && r.valid_pn_mask == '0 && pn_part)
                r.repeat_request = 1'b0;
            if (r.repeat_request)
                r.indication = 1'b1;
        end
        fr_count = '0;
        fr_nid   = '0;
        fr_cbv   = '0;
        fr_bits  = '0;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // register write; cfg_we stays high across back-to-back writes
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PDU_LENGTH:      cur_pdu_len   = val[6:0];
            REG_CBV_POSITION:    cur_cbv_pos   = val[6:0];
            REG_NID_POSITION:    cur_nid_pos   = val[6:0];
            REG_MODE_FLAGS:      cur_mode      = val[2:0];
            REG_DETECT_NODE:     cur_detect    = val[0];
            REG_PN_CONFIG_MASK:  cur_pn_mask   = val;
            REG_PN_FILTER_MASK:  cur_flt_mask  = val;
            REG_PN_FILTER_BYTES: cur_flt_bytes = val[3:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every byte is in and every verdict is out, then let the
    // pipeline settle
    task automatic wait_settled();
        while (rx_bytes.size() != 0 || s_tvalid || verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin);
        rx_req_t req;
        req.data = b;
        req.fin  = fin;
        rx_bytes.insert(rx_bytes.size(), req);
    endtask

    function automatic logic [6:0] pick_position(input int span);
        case ($urandom_range(0, 5))
            0:       return 7'h7F;                          // absent
            1:       return 7'($urandom_range(64, 126));    // other negative codes
            2:       return 7'($urandom_range(0, 63));      // often beyond the frame
            default: return 7'($urandom_range(0, span - 1));
        endcase
    endfunction

    function automatic logic [63:0] pick_mask();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic pick_settings();
        logic [6:0] len;
        int         span;
        case ($urandom_range(0, 9))
            0:       len = 7'd1;
            1:       len = 7'd64;
            2:       len = 7'($urandom_range(65, 127));   // can never match
            3:       len = 7'd0;
            default: len = 7'($urandom_range(2, 12));
        endcase
        span = (len >= 7'd1 && len <= 7'd64) ? int'(len) : 8;
        write_reg(REG_PDU_LENGTH, 64'(len));
        write_reg(REG_CBV_POSITION, 64'(pick_position(span)));
        write_reg(REG_NID_POSITION, 64'(pick_position(span)));
        write_reg(REG_MODE_FLAGS, 64'($urandom_range(0, 7)));
        write_reg(REG_DETECT_NODE, 64'($urandom_range(0, 1)));
        write_reg(REG_PN_CONFIG_MASK, pick_mask());
        write_reg(REG_PN_FILTER_MASK, pick_mask());
        write_reg(REG_PN_FILTER_BYTES, 64'($urandom_range(0, 15)));
        end_writes();
    endtask

    // one frame of random bytes; mostly the configured length, sometimes
    // short or long, now and then long enough to saturate the counter
    task automatic queue_frame();
        int         flen;
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            flen = $urandom_range(126, 140);
        else if (pick < 72 && cur_pdu_len >= 7'd1 && cur_pdu_len <= 7'd64)
            flen = cur_pdu_len;
        else
            flen = $urandom_range(1, 14);
        for (int k = 0; k < flen; k++)
        begin
            b = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            // lean the control byte towards carrying partial network info
            if (k == cur_cbv_pos && $urandom_range(0, 1))
                b[PNI_BIT_POS] = 1'b1;
            push_byte(b, k == flen - 1);
        end
    endtask

    // byte sender: a new request goes out once the previous one is taken
    always @(negedge clk)
    begin
        rx_req_t nxt;
        if (rst_n && (!s_tvalid || byte_taken))
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (rx_bytes.size() != 0 && $urandom_range(0, 99) < idle_odds)
            begin
                // start an idle burst
                s_tvalid <= 1'b0;
                send_gap = $urandom_range(0, 6);
            end
            else if (rx_bytes.size() != 0)
            begin
                nxt = rx_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.fin;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (recv_gap > 0)
        begin
            m_tready <= 1'b0;
            recv_gap = recv_gap - 1;
        end
        else if ($urandom_range(0, 99) < idle_odds)
        begin
            m_tready <= 1'b0;
            recv_gap = $urandom_range(0, 6);
        end
        else
            m_tready <= 1'b1;
    end

    // sample both sides at the rising edge: predict on taken bytes, check
    // each delivered verdict against the oldest one owed
    always @(posedge clk)
    begin
        result_t made;
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            byte_taken = s_tvalid && s_tready;
            if (byte_taken)
            begin
                if (filter_byte(s_tdata, s_tlast, made))
                    verdicts.insert(verdicts.size(), made);
            end
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[74:0];
                if (verdicts.size() == 0)
                    note_mismatch("verdict with none owed", m_tdata[63:0], '0);
                else
                begin
                    want = verdicts.pop_front();
                    if (seen.length_ok != want.length_ok)
                        note_mismatch("length_ok", 64'(seen.length_ok), 64'(want.length_ok));
                    if (seen.indication != want.indication)
                        note_mismatch("indication", 64'(seen.indication),
                                      64'(want.indication));
                    if (seen.node_id != want.node_id)
                        note_mismatch("node_id", 64'(seen.node_id), 64'(want.node_id));
                    if (seen.repeat_request != want.repeat_request)
                        note_mismatch("repeat_request", 64'(seen.repeat_request),
                                      64'(want.repeat_request));
                    if (seen.valid_pn_mask != want.valid_pn_mask)
                        note_mismatch("valid_pn_mask", seen.valid_pn_mask,
                                      want.valid_pn_mask);
                end
                if (m_tdata[79:75] != '0)
                    note_mismatch("pad bits", 64'(m_tdata[79:75]), '0);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_odds = 10;

        // reset defaults: full frame with repeat request and pni set, extreme bytes
        push_byte(8'h41, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'hFF, 1'b1);
        // length mismatch still gives a verdict, all fields cleared
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_settled();

        // short pdu, node id absent, all modes on, one filter byte
        write_reg(REG_PDU_LENGTH, 64'd2);
        write_reg(REG_CBV_POSITION, 64'd0);
        write_reg(REG_NID_POSITION, 64'h7F);
        write_reg(REG_MODE_FLAGS, 64'd7);
        write_reg(REG_DETECT_NODE, 64'd1);
        write_reg(REG_PN_CONFIG_MASK, '1);
        write_reg(REG_PN_FILTER_MASK, 64'h0000_0000_0000_F0F0);
        write_reg(REG_PN_FILTER_BYTES, 64'd1);
        end_writes();
        push_byte(8'hC1, 1'b0);
        push_byte(8'hFF, 1'b1);
        // no relevant network, so the repeat request is dropped by the pn check
        push_byte(8'h01, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_settled();

        // control byte position beyond the frame reads as zero
        write_reg(REG_CBV_POSITION, 64'd63);
        write_reg(REG_NID_POSITION, 64'd1);
        write_reg(REG_MODE_FLAGS, 64'd0);
        write_reg(REG_DETECT_NODE, 64'd0);
        end_writes();
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_settled();

        // random phases, each under fresh settings; the sender pauses at every
        // boundary until all verdicts are in, and the last phase runs flat out
        for (int p = 0; p < PHASES; p++)
        begin
            pick_settings();
            case (p % 4)
                0:       idle_odds = 8;
                1:       idle_odds = 25;
                2:       idle_odds = 0;
                default: idle_odds = 50;
            endcase
            if (p == PHASES - 1)
                idle_odds = 0;
            while (rx_bytes.size() < PHASE_BYTES)
                queue_frame();
            wait_settled();
        end

        repeat (2 * SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: nm_pdu_partial_network_filter.f
rtl/nmpn_pkg.sv
rtl/nmpn_cfg.sv
rtl/nmpn_acc.sv
rtl/nmpn_eval.sv
rtl/nm_pdu_partial_network_filter.sv
verif/nm_pdu_partial_network_filter_test.sv
